// ===== hw/rtl/fhc_pkg.sv =====
// Shared types, widths and filter coefficients for the FIR hysteresis classifier.
// Used by every module of the block; depends on nothing else.
package fhc_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_FRAC_BITS = 15;
	localparam int TAPS           = 9;
	localparam int CENTRE         = 4;
	localparam int PAIRS          = CENTRE;
	localparam int FILL_W         = $clog2(TAPS + 1);
	localparam int FILT_W         = 18;
	localparam int CFG_W          = 18;
	localparam int CFG_IDX_W      = 2;

	// Coefficient magnitudes stay below one, so F fraction bits, one integer bit and a sign fit.
	localparam int COEF_W  = COEF_FRAC_BITS + 2;
	localparam int PAIR_W  = SAMPLE_BITS + 1;
	localparam int PROD_W  = PAIR_W + COEF_W;
	localparam int ACC_W   = PROD_W + 3;
	localparam int SHIFT_W = ACC_W - COEF_FRAC_BITS;
	localparam int EXT_W   = (SHIFT_W > FILT_W) ? SHIFT_W + 1 : FILT_W + 1;

	// Coefficients in units of 1e-7, rounded half away from zero to Q1.F.
	localparam longint COEF_SCALE = 64'sd1 << COEF_FRAC_BITS;
	localparam longint Q0 = (331456 * COEF_SCALE + 5000000) / 10000000;
	localparam longint Q1 = (662900 * COEF_SCALE + 5000000) / 10000000;
	localparam longint Q2 = (1767700 * COEF_SCALE + 5000000) / 10000000;
	localparam longint Q3 = (4198440 * COEF_SCALE + 5000000) / 10000000;
	localparam longint Q4 = (9943680 * COEF_SCALE + 5000000) / 10000000;

	typedef logic signed [COEF_W-1:0] coef_t;

	// Outer pair first, centre tap last.
	localparam coef_t COEF [PAIRS+1] = '{
		COEF_W'(Q0), COEF_W'(Q1), COEF_W'(-Q2), COEF_W'(-Q3), COEF_W'(Q4)
	};

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [FILT_W-1:0]      filt_t;

	localparam filt_t FILT_MAX = filt_t'((1 << (FILT_W - 1)) - 1);
	localparam filt_t FILT_MIN = filt_t'(-(1 << (FILT_W - 1)));

	typedef enum logic [1:0] {
		CLASS_NONE = 2'd0,
		CLASS_LOW  = 2'd1,
		CLASS_HIGH = 2'd2
	} class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RISE_LOW   = 2'd0,
		REG_FALL_LOW   = 2'd1,
		REG_RISE_OTHER = 2'd2,
		REG_FALL_OTHER = 2'd3
	} cfg_reg_t;

	localparam filt_t RISE_LOW_RST   = filt_t'(250);
	localparam filt_t FALL_LOW_RST   = filt_t'(-460);
	localparam filt_t RISE_OTHER_RST = filt_t'(300);
	localparam filt_t FALL_OTHER_RST = filt_t'(-30);

	// Window status that follows an item down the pipeline.
	typedef struct packed {
		logic centre_ok;
		logic full;
	} win_flags_t;

endpackage

// ===== hw/rtl/fhc_window.sv =====
// Delay line, fill counter and first pipeline stage valid bit.
// Depends on fhc_pkg.
module fhc_window
	import fhc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic       drain,
	input  sample_t    sample,
	output sample_t    taps [TAPS],
	output win_flags_t flags,
	output logic       valid_s1
);

	sample_t            delay_q [TAPS];
	logic [FILL_W-1:0]  fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				delay_q[i] <= '0;
			end
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (load) begin
				delay_q[0] <= sample;
				for (int i = 1; i < TAPS; i++) begin
					delay_q[i] <= delay_q[i-1];
				end
				if (fill_q != FILL_W'(TAPS)) begin
					fill_q <= fill_q + FILL_W'(1);
				end
				valid_s1 <= 1'b1;
			end else if (drain) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign taps            = delay_q;
	assign flags.centre_ok = (fill_q > FILL_W'(CENTRE));
	assign flags.full      = (fill_q >= FILL_W'(TAPS));

endmodule

// ===== hw/rtl/fhc_mac.sv =====
// Symmetric pre-add and constant coefficient products, registered as stage two.
// Depends on fhc_pkg.
module fhc_mac
	import fhc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic       drain,
	input  sample_t    taps [TAPS],
	input  win_flags_t flags,
	output prod_t      prod_s2 [PAIRS+1],
	output sample_t    centre_s2,
	output win_flags_t flags_s2,
	output logic       valid_s2
);

	prod_t prod_d [PAIRS+1];

	always_comb begin
		logic signed [PAIR_W-1:0] pair;
		for (int k = 0; k < PAIRS; k++) begin
			pair      = PAIR_W'(taps[k]) + PAIR_W'(taps[TAPS-1-k]);
			prod_d[k] = PROD_W'(pair) * PROD_W'(COEF[k]);
		end
		prod_d[PAIRS] = PROD_W'(taps[CENTRE]) * PROD_W'(COEF[PAIRS]);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2   <= prod_d;
			centre_s2 <= taps[CENTRE];
			flags_s2  <= flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (drain) begin
			valid_s2 <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/fhc_classify.sv =====
// Sum, rounding, saturation, threshold registers, hysteresis class and result register.
// Depends on fhc_pkg.
module fhc_classify
	import fhc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 load,
	input  logic                 drain,
	input  prod_t                prod_s2 [PAIRS+1],
	input  sample_t              centre_s2,
	input  win_flags_t           flags_s2,
	output logic                 result_valid,
	output logic                 centre_valid,
	output sample_t              centre_sample,
	output filt_t                filtered,
	output logic [1:0]           class_code
);

	filt_t   rise_low_q, fall_low_q, rise_other_q, fall_other_q;
	class_t  class_q;
	logic    valid_q;
	logic    centre_valid_q;
	sample_t centre_q;
	filt_t   filt_q;

	logic signed [ACC_W-1:0]   acc;
	logic signed [SHIFT_W-1:0] shifted;
	logic signed [EXT_W-1:0]   ext;
	filt_t                     sat;
	filt_t                     filt_d;
	filt_t                     rise;
	filt_t                     fall;
	class_t                    class_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_low_q   <= RISE_LOW_RST;
			fall_low_q   <= FALL_LOW_RST;
			rise_other_q <= RISE_OTHER_RST;
			fall_other_q <= FALL_OTHER_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RISE_LOW:   rise_low_q   <= filt_t'(cfg_data);
				REG_FALL_LOW:   fall_low_q   <= filt_t'(cfg_data);
				REG_RISE_OTHER: rise_other_q <= filt_t'(cfg_data);
				REG_FALL_OTHER: fall_other_q <= filt_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// Round half up, floor shift back to sample units, then clamp.
	always_comb begin
		acc = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
		for (int k = 0; k <= PAIRS; k++) begin
			acc = acc + ACC_W'(prod_s2[k]);
		end
		shifted = SHIFT_W'(acc >>> COEF_FRAC_BITS);
		ext     = EXT_W'(shifted);
		if (ext > EXT_W'(FILT_MAX)) begin
			sat = FILT_MAX;
		end else if (ext < EXT_W'(FILT_MIN)) begin
			sat = FILT_MIN;
		end else begin
			sat = filt_t'(ext);
		end
		filt_d = flags_s2.full ? sat : '0;
	end

	// The fall test comes last so it wins when both thresholds fire.
	always_comb begin
		rise    = (class_q == CLASS_LOW) ? rise_low_q : rise_other_q;
		fall    = (class_q == CLASS_LOW) ? fall_low_q : fall_other_q;
		class_d = class_q;
		if (flags_s2.centre_ok) begin
			if (filt_d > rise) begin
				class_d = CLASS_HIGH;
			end
			if (filt_d < fall) begin
				class_d = CLASS_LOW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= CLASS_NONE;
			valid_q <= 1'b0;
		end else if (load) begin
			class_q <= class_d;
			valid_q <= 1'b1;
		end else if (drain) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			centre_valid_q <= flags_s2.centre_ok;
			centre_q       <= flags_s2.centre_ok ? centre_s2 : '0;
			filt_q         <= flags_s2.centre_ok ? filt_d : '0;
		end
	end

	assign result_valid  = valid_q;
	assign centre_valid  = centre_valid_q;
	assign centre_sample = centre_q;
	assign filtered      = filt_q;
	assign class_code    = class_q;

endmodule

// ===== hw/rtl/fir_hysteresis_classifier_unit.sv =====
// Top level of the symmetric 9-tap FIR with hysteresis classifier.
// Depends on fhc_pkg, fhc_window, fhc_mac and fhc_classify.
//
//   Channel   Signals                                        Direction
//   -------   --------------------------------------------   ---------
//   sample    sample_valid, sample_stall, sample             in
//   result    result_valid, result_stall, centre_valid,      out
//             centre_sample, filtered, class_code
//   config    cfg_we, cfg_index, cfg_data                    in
//
// The block takes one sample beat per clock while sample_stall is low and
// returns one result beat for each sample. Three registers carry it: the
// delay line is the first stage and loads at the accepting edge, the
// pre-added coefficient products the second, and the result register
// with the class state the third, each beat passing through them in turn.
// Reset clears the delay line, the fill counter, the class (to none), all
// stage valid bits, and loads the threshold registers with their defaults.
// Each stage moves forward whenever the stage after it is empty or moving,
// so bubbles close up and a sample beat is still taken while a finished
// result waits under result_stall, as long as an earlier stage is free.
// sample_stall rises only when all three stages hold beats and the result
// is stalled.
module fir_hysteresis_classifier_unit
	import fhc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 centre_valid,
	output sample_t              centre_sample,
	output filt_t                filtered,
	output logic [1:0]           class_code,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	sample_t    taps [TAPS];
	win_flags_t flags;
	logic       valid_s1;
	prod_t      prod_s2 [PAIRS+1];
	sample_t    centre_s2;
	win_flags_t flags_s2;
	logic       valid_s2;

	logic ready_out;
	logic ready_s2;
	logic ready_s1;
	logic accept;
	logic move_s1;
	logic move_s2;
	logic take_out;

	// Ready chain, from the result register back to the input.
	assign ready_out    = !result_valid || !result_stall;
	assign ready_s2     = !valid_s2 || ready_out;
	assign ready_s1     = !valid_s1 || ready_s2;
	assign sample_stall = !ready_s1;

	assign accept   = sample_valid && ready_s1;
	assign move_s1  = valid_s1 && ready_s2;
	assign move_s2  = valid_s2 && ready_out;
	assign take_out = result_valid && !result_stall;

	// The delay line shifts only as stage one takes a new beat, so it
	// always holds the window of the beat in stage one.
	fhc_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.drain    (move_s1),
		.sample   (sample),
		.taps     (taps),
		.flags    (flags),
		.valid_s1 (valid_s1)
	);

	fhc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (move_s1),
		.drain     (move_s2),
		.taps      (taps),
		.flags     (flags),
		.prod_s2   (prod_s2),
		.centre_s2 (centre_s2),
		.flags_s2  (flags_s2),
		.valid_s2  (valid_s2)
	);

	// The class state advances as each beat enters the result register,
	// so the next beat's thresholds see the updated class.
	fhc_classify u_classify (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.load          (move_s2),
		.drain         (take_out),
		.prod_s2       (prod_s2),
		.centre_s2     (centre_s2),
		.flags_s2      (flags_s2),
		.result_valid  (result_valid),
		.centre_valid  (centre_valid),
		.centre_sample (centre_sample),
		.filtered      (filtered),
		.class_code    (class_code)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for fir_hysteresis_classifier_unit: bursty samples, patterned stalls.
// Holds its own filter and classifier predictor; depends on fhc_pkg and the RTL only.
module testbench;
	import fhc_pkg::*;

	// Filter taps in Q1.15, rounded to nearest from the wavelet-like prototype.
	// The window is symmetric, so the newest-first order of the delay line is irrelevant.
	localparam int TAP_WEIGHT [9] = '{1086, 2172, -5792, -13757, 32583, -13757, -5792, 2172, 1086};
	localparam int WINDOW_LEN = 9;
	localparam int MID_TAP = 4;
	localparam int FRAC_SHIFT = 15;
	localparam int RANDOM_PER_PHASE = 244;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT = 400000;

	// Opening beats: extremes and alternating bit patterns, then a window that
	// matches the tap signs (largest positive output) and its inverse.
	localparam sample_t OPENING [25] = '{
		32767, -32768, 0, -1, 1, 21845, -21846,
		32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767,
		-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768
	};

	// Shapes of random sample bursts.
	typedef enum {WAVE_FULL, WAVE_QUIET, WAVE_EDGE, WAVE_STEP} wave_t;
	// Receiver stall styles, taken in rotation.
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_style_t;

	typedef struct {
		logic    centre_ok;
		sample_t centre;
		filt_t   filt;
		class_t  cls;
	} classified_beat_t;

	// Keeps a private copy of the delay line, fill count, class and thresholds,
	// turns each accepted sample into the result beat it must produce, and
	// checks the block's result beats against those in order.
	class classifier_scoreboard;
		sample_t          taps [WINDOW_LEN];
		int               fill;
		class_t           level;
		filt_t            thr [4];
		classified_beat_t expected_beats [$];
		int               mismatches;
		int               samples_noted;
		int               results_checked;
		int               class_seen [3];

		function new();
			foreach (taps[i]) taps[i] = '0;
			fill = 0;
			level = CLASS_NONE;
			thr[REG_RISE_LOW] = RISE_LOW_RST;
			thr[REG_FALL_LOW] = FALL_LOW_RST;
			thr[REG_RISE_OTHER] = RISE_OTHER_RST;
			thr[REG_FALL_OTHER] = FALL_OTHER_RST;
			mismatches = 0;
			samples_noted = 0;
			results_checked = 0;
			class_seen = '{0, 0, 0};
		endfunction

		function void set_threshold(cfg_reg_t idx, filt_t value);
			thr[idx] = value;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		function void note_sample(sample_t s);
			classified_beat_t e;
			filt_t rise;
			filt_t fall;
			longint acc;
			longint scaled;
			for (int i = WINDOW_LEN - 1; i > 0; i--) taps[i] = taps[i-1];
			taps[0] = s;
			if (fill < WINDOW_LEN) fill++;
			samples_noted++;
			e.centre_ok = (fill > MID_TAP);
			e.centre = '0;
			e.filt = '0;
			if (e.centre_ok) begin
				rise = (level == CLASS_LOW) ? thr[REG_RISE_LOW] : thr[REG_RISE_OTHER];
				fall = (level == CLASS_LOW) ? thr[REG_FALL_LOW] : thr[REG_FALL_OTHER];
				e.centre = taps[MID_TAP];
				if (fill >= WINDOW_LEN) begin
					acc = longint'(1) <<< (FRAC_SHIFT - 1);
					for (int i = 0; i < WINDOW_LEN; i++)
						acc += longint'(taps[i]) * longint'(TAP_WEIGHT[i]);
					scaled = acc >>> FRAC_SHIFT;
					if (scaled > longint'(FILT_MAX)) scaled = longint'(FILT_MAX);
					if (scaled < longint'(FILT_MIN)) scaled = longint'(FILT_MIN);
					e.filt = filt_t'(scaled);
				end
				// Fall is tested last so it wins when both thresholds fire.
				if (e.filt > rise) level = CLASS_HIGH;
				if (e.filt < fall) level = CLASS_LOW;
			end
			e.cls = level;
			expected_beats.push_back(e);
		endfunction

		function void check_result(logic cv, sample_t cs, filt_t fv, logic [1:0] cc);
			classified_beat_t e;
			results_checked++;
			if (cc < 3) class_seen[cc]++;
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing outstanding (valid=%0b centre=%0d filtered=%0d class=%0d)",
						$time, cv, cs, fv, cc);
				return;
			end
			e = expected_beats.pop_front();
			if (e.centre_ok !== cv || e.centre !== cs || e.filt !== fv || e.cls !== cc) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch expected valid=%0b centre=%0d filtered=%0d class=%0d, got valid=%0b centre=%0d filtered=%0d class=%0d",
						$time, e.centre_ok, e.centre, e.filt, e.cls, cv, cs, fv, cc);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	sample_t              sample = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic                 centre_valid;
	sample_t              centre_sample;
	filt_t                filtered;
	logic [1:0]           class_code;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	classifier_scoreboard sb;
	sample_t held_level = '0;
	int phases_run = 0;
	int stall_cycle = 0;
	int cycle_count = 0;

	fir_hysteresis_classifier_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.centre_valid (centre_valid),
		.centre_sample(centre_sample),
		.filtered     (filtered),
		.class_code   (class_code),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver side. The stall style rotates between none, light random,
	// heavy random and a fixed comb, so back-pressure lands on every pipeline
	// phase and there are also long stretches where results flow freely.
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			case (stall_style_t'((stall_cycle / 150) % 4))
				STALL_NONE:  result_stall <= 1'b0;
				STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: result_stall <= ($urandom_range(0, 9) < 7);
				default:     result_stall <= ((stall_cycle % 5) < 2);
			endcase
		end
	end

	// Result beats are taken at the edge where valid is high and stall low.
	// Reading at the edge sees the values from before it, since every driver
	// here and in the block updates through nonblocking assignments.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(centre_valid, centre_sample, filtered, class_code);
	end

	// Hard stop in case the block hangs.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d beats outstanding.", cycle_count, sb.pending());
		$display("[fir_hysteresis_classifier_unit] ERROR");
		$finish;
	end

	// Presents one sample beat and holds it until the block takes it. Must be
	// entered right at a rising edge; returns at the edge of acceptance.
	task automatic push_sample(input sample_t v);
		sample_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (sample_stall);
		sb.note_sample(v);
	endtask

	task automatic idle_sender(input int cycles);
		sample_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic sample_t pick_sample(wave_t shape);
		case (shape)
			WAVE_FULL:  return sample_t'($urandom);
			// Quiet noise keeps the filter output near the thresholds.
			WAVE_QUIET: return sample_t'(int'($urandom_range(0, 1200)) - 600);
			WAVE_EDGE: begin
				case ($urandom_range(0, 3))
					0: return 32767;
					1: return -32768;
					2: return 0;
					default: return -1;
				endcase
			end
			default: begin
				// Held level with occasional jumps gives step responses.
				if ($urandom_range(0, 7) == 0) held_level = sample_t'($urandom);
				return held_level;
			end
		endcase
	endfunction

	// Random samples in bursts of random shape and length, with random gaps
	// and some back-to-back bursts.
	task automatic run_random(input int count);
		int left;
		int burst;
		wave_t shape;
		int pick;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			if (burst > left) burst = left;
			pick = $urandom_range(0, 9);
			shape = (pick < 4) ? WAVE_FULL : (pick < 7) ? WAVE_QUIET : (pick < 8) ? WAVE_EDGE : WAVE_STEP;
			repeat (burst) push_sample(pick_sample(shape));
			left -= burst;
			if ($urandom_range(0, 9) >= 3) idle_sender($urandom_range(1, 8));
		end
	endtask

	// Waits until every outstanding result beat has been checked, then lets
	// the three-stage pipeline settle before anything else is changed.
	task automatic drain();
		sample_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all four thresholds, one per cycle, with the block idle.
	task automatic write_thresholds(input filt_t rise_low, fall_low, rise_other, fall_other);
		filt_t vals [4];
		vals = '{rise_low, fall_low, rise_other, fall_other};
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_t'(k);
			cfg_data <= vals[k];
			@(posedge clk);
			sb.set_threshold(cfg_reg_t'(k), vals[k]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input filt_t rise_low, fall_low, rise_other, fall_other);
		write_thresholds(rise_low, fall_low, rise_other, fall_other);
		run_random(RANDOM_PER_PHASE);
		drain();
		phases_run++;
	endtask

	function automatic filt_t random_level();
		return filt_t'(int'($urandom_range(0, 4000)) - 2000);
	endfunction

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default thresholds. The opening beats walk through the start-up
		// cases: no centre yet, centre with a partial window, then a full
		// window driven to both extremes of the filter output.
		foreach (OPENING[i]) push_sample(OPENING[i]);
		run_random(RANDOM_PER_PHASE);
		drain();
		phases_run++;

		// Every threshold at the top: nothing rises, everything falls.
		run_phase(FILT_MAX, FILT_MAX, FILT_MAX, FILT_MAX);
		// Every threshold at the bottom: everything rises, nothing falls.
		run_phase(FILT_MIN, FILT_MIN, FILT_MIN, FILT_MIN);
		// Mixed extremes: once low, both thresholds fire and low must hold;
		// from none or high nothing fires.
		run_phase(FILT_MIN, FILT_MAX, FILT_MAX, FILT_MIN);
		// Overlapping windows near zero, so rise and fall often fire together.
		run_phase(-50, 50, -20, 20);
		// Narrow ordinary hysteresis.
		run_phase(100, -100, 200, -200);
		// Two settings drawn at random.
		run_phase(random_level(), random_level(), random_level(), random_level());
		run_phase(random_level(), random_level(), random_level(), random_level());

		$display("Covered %0d sample beats over %0d threshold settings, with bursty input and rotating stalls.",
			sb.samples_noted, phases_run);
		$display("Checked %0d result beats (none %0d, low %0d, high %0d); %0d mismatches.",
			sb.results_checked, sb.class_seen[0], sb.class_seen[1], sb.class_seen[2], sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("[fir_hysteresis_classifier_unit] OK");
		end else begin
			$display("[fir_hysteresis_classifier_unit] ERROR");
		end
		$finish;
	end

endmodule
